@@ rtl/ppu_pkg.sv @@
// Shared types and constants for the PPP byte unstuffer.
// Used by the channel interfaces and by ppp_byte_unstuffer. No dependencies.
package ppu_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 9;
  localparam int unsigned STATUS_W = 3;

  localparam int unsigned MAX_MESSAGE_BYTES_DEF = 256;

  localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
  localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h7D;
  localparam logic [BYTE_W-1:0] ESC_XOR   = 8'h20;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK         = 3'd0,
    STATUS_TOO_SHORT  = 3'd1,
    STATUS_NO_FLAG    = 3'd2,
    STATUS_TOO_LONG   = 3'd3,
    STATUS_LEN_MISMAT = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_AWAIT  = 2'd0,
    ST_BODY   = 2'd1,
    ST_IGNORE = 2'd2
  } stage_e;

  typedef struct packed {
    logic                kind;
    logic [BYTE_W-1:0]   data_byte;
    logic [BYTE_W-1:0]   byte_index;
    logic [STATUS_W-1:0] status;
    logic                last;
  } result_t;

endpackage

@@ rtl/ppu_in_if.sv @@
// Input channel of the PPP byte unstuffer: one raw byte per word.
// Depends on ppu_pkg for field widths.
interface ppu_in_if;
  import ppu_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] stuffed_byte;
  logic              frame_end;

  modport source (output valid, output stuffed_byte, output frame_end, input ready);
  modport sink   (input valid, input stuffed_byte, input frame_end, output ready);
endinterface

@@ rtl/ppu_out_if.sv @@
// Result channel of the PPP byte unstuffer: decoded data or frame status.
// Depends on ppu_pkg for field widths.
interface ppu_out_if;
  import ppu_pkg::*;

  logic                valid;
  logic                ready;
  logic                kind;
  logic [BYTE_W-1:0]   data_byte;
  logic [BYTE_W-1:0]   byte_index;
  logic [STATUS_W-1:0] status;
  logic                last;

  modport source (output valid, output kind, output data_byte, output byte_index,
                  output status, output last, input ready);
  modport sink   (input valid, input kind, input data_byte, input byte_index,
                  input status, input last, output ready);
endinterface

@@ rtl/ppu_cfg_if.sv @@
// Configuration write channel of the PPP byte unstuffer (expected length).
// Depends on ppu_pkg for the register width.
interface ppu_cfg_if;
  import ppu_pkg::*;

  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] expected_length;

  modport source (output valid, output expected_length, input ready);
  modport sink   (input valid, input expected_length, output ready);
endinterface

@@ rtl/ppp_byte_unstuffer.sv @@
// PPP/HDLC byte unstuffer: flag and escape removal with frame status.
// Depends on ppu_pkg, ppu_in_if, ppu_out_if and ppu_cfg_if.
//
// Raw frame bytes enter one word per cycle; frame_end marks the last byte.
// Each decoded byte is queued as tentative data with its message index,
// and the final byte adds one status word; the consumer drops the frame's
// data unless that status is ok. Results are registered in a four-entry
// result queue that drains one word per cycle while out_o.ready is high.
// The input takes a word every cycle while at least two queue slots
// are free, so the sustained rate is one input word per cycle when each word
// makes at most one result; a closing word that carries both a data byte
// and a status pushes two queue words. The expected length register may be
// written at any time the block is idle and needs no clearing after reset.
module ppp_byte_unstuffer #(
  parameter int unsigned MaxMessageBytes = ppu_pkg::MAX_MESSAGE_BYTES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ppu_cfg_if.sink   cfg_i,
  ppu_in_if.sink    in_i,
  ppu_out_if.source out_o
);
  import ppu_pkg::*;

  localparam int unsigned CNT_W   = $clog2(MaxMessageBytes + 1);
  localparam int unsigned CMP_W   = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // Frame state
  stage_e            stage_q, stage_d;
  logic              esc_q, esc_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              flag_bad_q, flag_bad_d;
  logic              overflow_q, overflow_d;
  logic [LEN_W-1:0]  exp_len_q;

  // Result queue
  result_t           queue_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] qcount_q;

  logic              in_fire, out_fire;
  logic [BYTE_W-1:0] in_byte;
  logic              fin;
  logic              is_flag, is_esc, is_full;
  logic [CMP_W-1:0]  cnt_ext, exp_ext, max_ext, cnt_next_ext;

  logic              data_v, stat_v;
  logic [BYTE_W-1:0] data_val;
  status_e           stat_code;
  result_t           res0, res1;
  logic [1:0]        push_n;

  assign in_byte = in_i.stuffed_byte;
  assign fin     = in_i.frame_end;
  assign is_flag = (in_byte == FLAG_BYTE);
  assign is_esc  = (in_byte == ESC_BYTE);

  assign cnt_ext = CMP_W'(count_q);
  assign exp_ext = CMP_W'(exp_len_q);
  assign max_ext = CMP_W'(MaxMessageBytes);
  assign is_full = (cnt_ext >= exp_ext) || (cnt_ext >= max_ext);

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (qcount_q <= QCNT_W'(QDEPTH - 2));
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_o.valid = (qcount_q != '0);
  assign out_fire    = out_o.valid && out_o.ready;

  // Next stage
  always_comb begin
    stage_d = stage_q;
    case (stage_q)
      ST_AWAIT: begin
        if (is_flag) begin
          stage_d = ST_BODY;
        end else begin
          stage_d = ST_IGNORE;
        end
      end
      ST_BODY: begin
        if (!esc_q && (is_flag || is_full)) begin
          stage_d = ST_IGNORE;
        end
      end
      ST_IGNORE: stage_d = ST_IGNORE;
      default:   stage_d = ST_AWAIT;
    endcase
    if (fin) begin
      stage_d = ST_AWAIT;
    end
  end

  // Decode, counters and results
  always_comb begin
    esc_d      = esc_q;
    count_d    = count_q;
    flag_bad_d = flag_bad_q;
    overflow_d = overflow_q;
    data_v     = 1'b0;
    data_val   = in_byte;
    stat_v     = 1'b0;
    stat_code  = STATUS_OK;

    case (stage_q)
      ST_AWAIT: begin
        if (!fin && !is_flag) begin
          flag_bad_d = 1'b1;
        end
      end
      ST_BODY: begin
        if (esc_q) begin
          esc_d    = 1'b0;
          data_v   = 1'b1;
          data_val = in_byte ^ ESC_XOR;
          count_d  = count_q + CNT_W'(1);
        end else if (is_flag) begin
          // Closing flag: the rest of the frame is ignored.
        end else if (is_full) begin
          overflow_d = 1'b1;
        end else if (is_esc) begin
          esc_d = 1'b1;
        end else begin
          data_v  = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      ST_IGNORE: begin
      end
      default: begin
      end
    endcase

    cnt_next_ext = CMP_W'(count_d);

    if (fin) begin
      stat_v = 1'b1;
      if (stage_q == ST_AWAIT) begin
        stat_code = STATUS_TOO_SHORT;
      end else if (flag_bad_d || !is_flag) begin
        stat_code = STATUS_NO_FLAG;
      end else if (overflow_d) begin
        stat_code = STATUS_TOO_LONG;
      end else if (cnt_next_ext != exp_ext) begin
        stat_code = STATUS_LEN_MISMAT;
      end else begin
        stat_code = STATUS_OK;
      end
      esc_d      = 1'b0;
      count_d    = '0;
      flag_bad_d = 1'b0;
      overflow_d = 1'b0;
    end
  end

  always_comb begin
    result_t d_res, s_res;
    d_res.kind       = KIND_DATA;
    d_res.data_byte  = data_val;
    d_res.byte_index = cnt_ext[BYTE_W-1:0];
    d_res.status     = STATUS_OK;
    d_res.last       = !stat_v;
    s_res.kind       = KIND_STATUS;
    s_res.data_byte  = '0;
    s_res.byte_index = '0;
    s_res.status     = stat_code;
    s_res.last       = 1'b1;
    res0   = data_v ? d_res : s_res;
    res1   = s_res;
    push_n = in_fire ? ({1'b0, data_v} + {1'b0, stat_v}) : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q    <= ST_AWAIT;
      esc_q      <= 1'b0;
      count_q    <= '0;
      flag_bad_q <= 1'b0;
      overflow_q <= 1'b0;
      exp_len_q  <= '0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      qcount_q   <= '0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        exp_len_q <= cfg_i.expected_length;
      end
      if (in_fire) begin
        stage_q    <= stage_d;
        esc_q      <= esc_d;
        count_q    <= count_d;
        flag_bad_q <= flag_bad_d;
        overflow_q <= overflow_d;
      end
      wr_ptr_q <= wr_ptr_q + QPTR_W'(push_n);
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      qcount_q <= qcount_q + QCNT_W'(push_n) - QCNT_W'(out_fire);
    end
  end

  // Queue payload, no reset needed.
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (push_n == 2'd2) begin
      queue_q[wr_ptr_q + QPTR_W'(1)] <= res1;
    end
  end

  result_t head;
  assign head             = queue_q[rd_ptr_q];
  assign out_o.kind       = head.kind;
  assign out_o.data_byte  = head.data_byte;
  assign out_o.byte_index = head.byte_index;
  assign out_o.status     = head.status;
  assign out_o.last       = head.last;

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qcount_q <= QCNT_W'(QDEPTH))
    else $error("result queue holds more words than its depth");

  a_data_in_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && data_v) |-> (stage_q == ST_BODY))
    else $error("data produced outside the frame body");

  a_frame_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && fin) |=> (stage_q == ST_AWAIT && count_q == '0 && !esc_q
                          && !flag_bad_q && !overflow_q))
    else $error("frame state not cleared after the final byte");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(count_q) <= max_ext)
    else $error("decoded count beyond the message buffer");

  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind == KIND_STATUS) |->
      (out_o.data_byte == '0 && out_o.byte_index == '0 && out_o.last))
    else $error("status word carries data fields or is not last");

endmodule
